// File: sv/eews_pkg.sv
// ============================================================================
// EEPROM word store package
// Shared beat types, action and operation codes, control groups, the state
// machine type and the CRC-16 byte step of the EEPROM word store.
// ============================================================================
`default_nettype none

package eews_pkg;

    // Actions carried by an input beat.
    localparam logic [2:0] ACT_SELECT = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_ERASE  = 3'd2;
    localparam logic [2:0] ACT_ERAL   = 3'd3;
    localparam logic [2:0] ACT_WRAL   = 3'd4;
    localparam logic [2:0] ACT_TICK   = 3'd5;

    // CRC-16 constants: polynomial, seed and the value of an erased word.
    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] ERASED     = 16'hFFFF;

    // Pending operation held between its start and the completing tick.
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_WRITE = 3'd1,
        OP_ERASE = 3'd2,
        OP_ERAL  = 3'd3,
        OP_WRAL  = 3'd4
    } op_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_CRC_WR,
        ST_RD,
        ST_RESP
    } state_t;

    // Input beat.
    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  word_address;
        logic [15:0] write_value;
    } item_t;

    // Output beat.
    typedef struct packed {
        logic        busy_res;
        logic [15:0] read_word;
        logic        accepted;
    } result_t;

    // Memory port controls.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic fill;
    } mem_ctl_t;

    // CRC unit controls.
    typedef struct packed {
        logic init;
        logic shift;
        logic hi;
    } crc_ctl_t;

    // One byte of CRC-16, MSB first, no reflection.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/eeprom_word_store_with_crc.sv
// ============================================================================
// EEPROM word store with CRC
// Top level: beat decode, operation sequencer, CRC walk and result register.
// ============================================================================
// Usage:
//   Input beats arrive on item/item_valid/item_stall and each one yields
//   exactly one result beat on result/result_valid/result_stall.
//   A beat selects an address, starts a write, erase, erase-all or
//   write-all, or ticks to complete the pending operation.
//   Sequence: a beat that does not refresh the CRC passes through the
//   EXEC, RD and RESP states into the result register. A tick that
//   completes an operation and refreshes the CRC in the last word walks
//   words 0 to WORDS-2; the walk reads one word per CRC_LO/CRC_HI pair
//   through the memory read port and folds in one byte per cycle.
//   Flow: one beat is in work at a time; item_stall is high from
//   acceptance until the result is placed in the output register.
//   The output register lets the next beat be accepted while a result
//   still waits; if result_stall holds, the following result waits in the
//   sequencer and item_stall stays high.
//   Reset clears the selection and the pending operation and makes every
//   word read as 0xFFFF at once, with no clearing pass.
// ============================================================================
`default_nettype none

module eeprom_word_store_with_crc #(
    parameter int WORDS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire eews_pkg::item_t   item,
    input  wire logic              item_valid,
    output logic                   item_stall,
    output eews_pkg::result_t      result,
    output logic                   result_valid,
    input  wire logic              result_stall
);

    localparam int AW = $clog2(WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);
    localparam logic [AW-1:0] CRC_END   = AW'(WORDS - 2);

    eews_pkg::state_t   state_reg, state_next;
    eews_pkg::op_t      pend_op_reg;
    eews_pkg::op_t      op_reg;
    logic [5:0]         sel_reg;
    logic [15:0]        pend_value_reg;
    logic               acc_reg;
    logic [AW-1:0]      ctr_reg;
    eews_pkg::result_t  result_reg;
    logic               result_valid_reg;

    eews_pkg::mem_ctl_t mem_ctl;
    eews_pkg::crc_ctl_t crc_ctl;
    logic [AW-1:0]      wr_addr;
    logic [15:0]        wr_data;
    logic [15:0]        fill_value;
    logic [AW-1:0]      rd_addr;
    logic [15:0]        rd_data;
    logic [15:0]        crc;

    logic               item_take;
    logic               result_load;
    logic               sel_in_range;
    logic               sel_is_last;
    logic [AW-1:0]      sel_idx;
    logic               crc_go;
    logic               busy;

    // Handshake terms.
    assign item_take   = item_valid && !item_stall;
    assign item_stall  = (state_reg != eews_pkg::ST_IDLE);
    assign result_load = (state_reg == eews_pkg::ST_RESP) &&
                         (!result_valid_reg || !result_stall);

    // Selected address seen against the store size.
    assign sel_in_range = (32'(sel_reg) < WORDS);
    assign sel_is_last  = (32'(sel_reg) == WORDS - 1);
    assign sel_idx      = AW'(sel_reg);

    // A completed operation refreshes the CRC unless it only touched the
    // last word or an address past the store.
    always_comb
    begin
        unique case (op_reg)
            eews_pkg::OP_WRITE,
            eews_pkg::OP_ERASE: crc_go = sel_in_range && !sel_is_last;
            eews_pkg::OP_ERAL,
            eews_pkg::OP_WRAL:  crc_go = 1'b1;
            default:            crc_go = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eews_pkg::ST_IDLE:
            begin
                if (item_take)
                    state_next = eews_pkg::ST_EXEC;
            end
            eews_pkg::ST_EXEC:
            begin
                state_next = crc_go ? eews_pkg::ST_CRC_LO : eews_pkg::ST_RD;
            end
            eews_pkg::ST_CRC_LO:
            begin
                state_next = eews_pkg::ST_CRC_HI;
            end
            eews_pkg::ST_CRC_HI:
            begin
                state_next = (ctr_reg == CRC_END) ? eews_pkg::ST_CRC_WR
                                                  : eews_pkg::ST_CRC_LO;
            end
            eews_pkg::ST_CRC_WR:
            begin
                state_next = eews_pkg::ST_RD;
            end
            eews_pkg::ST_RD:
            begin
                state_next = eews_pkg::ST_RESP;
            end
            eews_pkg::ST_RESP:
            begin
                if (result_load)
                    state_next = eews_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = eews_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory and CRC controls for each state.
    always_comb
    begin
        mem_ctl    = '0;
        crc_ctl    = '0;
        wr_addr    = sel_idx;
        wr_data    = eews_pkg::ERASED;
        fill_value = eews_pkg::ERASED;
        rd_addr    = '0;
        unique case (state_reg)
            eews_pkg::ST_EXEC:
            begin
                if (op_reg == eews_pkg::OP_WRITE || op_reg == eews_pkg::OP_ERASE)
                begin
                    mem_ctl.wr_en = sel_in_range;
                    if (op_reg == eews_pkg::OP_WRITE)
                        wr_data = pend_value_reg;
                end
                if (op_reg == eews_pkg::OP_ERAL || op_reg == eews_pkg::OP_WRAL)
                begin
                    mem_ctl.fill = 1'b1;
                    if (op_reg == eews_pkg::OP_WRAL)
                        fill_value = pend_value_reg;
                end
                // Start the walk at word zero.
                mem_ctl.rd_en = crc_go;
                crc_ctl.init  = crc_go;
            end
            eews_pkg::ST_CRC_LO:
            begin
                crc_ctl.shift = 1'b1;
            end
            eews_pkg::ST_CRC_HI:
            begin
                crc_ctl.shift = 1'b1;
                crc_ctl.hi    = 1'b1;
                mem_ctl.rd_en = (ctr_reg != CRC_END);
                rd_addr       = ctr_reg + 1'b1;
            end
            eews_pkg::ST_CRC_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = LAST_ADDR;
                wr_data       = crc;
            end
            eews_pkg::ST_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = sel_idx;
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= eews_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Beat decode: selection, pending operation and the accept flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg        <= '0;
            pend_value_reg <= '0;
            pend_op_reg    <= eews_pkg::OP_IDLE;
            op_reg         <= eews_pkg::OP_IDLE;
            acc_reg        <= 1'b0;
        end
        else if (item_take)
        begin
            unique case (item.action)
                eews_pkg::ACT_SELECT:
                begin
                    sel_reg     <= item.word_address;
                    pend_op_reg <= eews_pkg::OP_IDLE;
                    op_reg      <= eews_pkg::OP_IDLE;
                    acc_reg     <= 1'b1;
                end
                eews_pkg::ACT_WRITE:
                begin
                    op_reg  <= eews_pkg::OP_IDLE;
                    acc_reg <= !busy;
                    if (!busy)
                    begin
                        sel_reg        <= item.word_address;
                        pend_value_reg <= item.write_value;
                        pend_op_reg    <= eews_pkg::OP_WRITE;
                    end
                end
                eews_pkg::ACT_ERASE:
                begin
                    op_reg  <= eews_pkg::OP_IDLE;
                    acc_reg <= !busy;
                    if (!busy)
                    begin
                        sel_reg     <= item.word_address;
                        pend_op_reg <= eews_pkg::OP_ERASE;
                    end
                end
                eews_pkg::ACT_ERAL:
                begin
                    op_reg  <= eews_pkg::OP_IDLE;
                    acc_reg <= !busy;
                    if (!busy)
                        pend_op_reg <= eews_pkg::OP_ERAL;
                end
                eews_pkg::ACT_WRAL:
                begin
                    op_reg  <= eews_pkg::OP_IDLE;
                    acc_reg <= !busy;
                    if (!busy)
                    begin
                        pend_value_reg <= item.write_value;
                        pend_op_reg    <= eews_pkg::OP_WRAL;
                    end
                end
                eews_pkg::ACT_TICK:
                begin
                    op_reg      <= pend_op_reg;
                    pend_op_reg <= eews_pkg::OP_IDLE;
                    acc_reg     <= 1'b1;
                end
                default:
                begin
                    op_reg  <= eews_pkg::OP_IDLE;
                    acc_reg <= 1'b0;
                end
            endcase
        end
    end

    // Word counter of the CRC walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctr_reg <= '0;
        else if (state_reg == eews_pkg::ST_EXEC)
            ctr_reg <= '0;
        else if (state_reg == eews_pkg::ST_CRC_HI && ctr_reg != CRC_END)
            ctr_reg <= ctr_reg + 1'b1;
    end

    // Result register: busy, byte-swapped word and accept flag.
    assign busy = (pend_op_reg != eews_pkg::OP_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_load)
            begin
                result_valid_reg     <= 1'b1;
                result_reg.busy_res  <= busy;
                result_reg.accepted  <= acc_reg;
                result_reg.read_word <= (!busy && sel_in_range) ?
                                        {rd_data[7:0], rd_data[15:8]} : 16'h0000;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Word memory.
    eews_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mem_ctl),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .fill_value (fill_value),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // CRC accumulator.
    eews_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .word  (rd_data),
        .crc   (crc)
    );

    // A busy result never carries a stored word.
    a_busy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.busy_res) |-> (result.read_word == 16'h0000))
        else $error("busy result carries a nonzero word");

    // The CRC word is written only right after the last high byte.
    a_crc_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eews_pkg::ST_CRC_WR) |->
        ($past(state_reg) == eews_pkg::ST_CRC_HI && $past(ctr_reg) == CRC_END))
        else $error("CRC word written out of order");

    // The walk never passes the word before the last.
    a_ctr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eews_pkg::ST_CRC_LO || state_reg == eews_pkg::ST_CRC_HI) |->
        (32'(ctr_reg) <= WORDS - 2))
        else $error("CRC walk out of range");

    // A loaded result is presented in the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> result_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: sv/eews_mem.sv
// ============================================================================
// EEPROM word store memory
// Synchronous word memory with one write and one registered read port, a
// valid bit per word and a fill value that answers for words not yet written.
// ============================================================================
`default_nettype none

module eews_mem #(
    parameter int WORDS = 64,
    parameter int AW    = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire eews_pkg::mem_ctl_t   ctl,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [15:0]          wr_data,
    input  wire logic [15:0]          fill_value,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [15:0]          rd_data
);

    logic [15:0]      ram_reg [WORDS];
    logic [15:0]      rd_word_reg;
    logic             hit_reg;
    logic [WORDS-1:0] valid_reg;
    logic [15:0]      base_reg;

    // Memory array: write port and registered read port, with the write
    // forwarded when both touch the same word.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            ram_reg[wr_addr] <= wr_data;
        if (ctl.rd_en)
        begin
            if (ctl.wr_en && (wr_addr == rd_addr))
                rd_word_reg <= wr_data;
            else
                rd_word_reg <= ram_reg[rd_addr];
        end
    end

    // Valid bits and fill value; a fill marks every word as holding the
    // fill value at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            base_reg  <= eews_pkg::ERASED;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.fill)
            begin
                valid_reg <= '0;
                base_reg  <= fill_value;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                if (ctl.fill)
                    hit_reg <= 1'b0;
                else if (ctl.wr_en && (wr_addr == rd_addr))
                    hit_reg <= 1'b1;
                else
                    hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A word never written since the last fill reads as the fill value.
    assign rd_data = hit_reg ? rd_word_reg : base_reg;

endmodule

`default_nettype wire

// File: sv/eews_crc.sv
// ============================================================================
// EEPROM word store CRC unit
// CRC-16 accumulator that folds in one byte of a memory word per cycle
// while shift is set, low byte first.
// ============================================================================
`default_nettype none

module eews_crc (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire eews_pkg::crc_ctl_t  ctl,
    input  wire logic [15:0]         word,
    output logic      [15:0]         crc
);

    logic [15:0] crc_reg;
    logic [7:0]  byte_sel;

    // Pick the byte of the current word.
    assign byte_sel = ctl.hi ? word[15:8] : word[7:0];

    // Accumulator: seed on start, one byte step per shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= eews_pkg::CRC_SEED;
        else if (ctl.init)
            crc_reg <= eews_pkg::CRC_SEED;
        else if (ctl.shift)
            crc_reg <= eews_pkg::crc_byte(crc_reg, byte_sel);
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire
